[rtl/scba_pkg.sv]
package scba_pkg;

  localparam int unsigned MinBlock   = 16;
  localparam int unsigned MinShift   = 4;
  localparam int unsigned IdxWMax    = 22;
  localparam int unsigned BinW       = 3;
  localparam int unsigned AddrW      = 18;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned AlignW     = 8;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned CfgW       = 7;
  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  typedef enum logic [StatusW-1:0] {
    ST_ALLOC   = 3'd0,
    ST_FREED   = 3'd1,
    ST_GENERAL = 3'd2,
    ST_ALIGNED = 3'd3,
    ST_NOPAGE  = 3'd4,
    ST_NULL    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CMD_NULL,
    CMD_GENERAL,
    CMD_ALIGNED,
    CMD_FREE,
    CMD_ALLOC
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [BinW-1:0]    bin;
    logic [IdxWMax-1:0] idx;
  } cmd_t;

  typedef enum logic {
    F_IDLE,
    F_REDUCE
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DECODE,
    B_POP,
    B_CARVE,
    B_DONE
  } back_state_e;

  // Number of bins whose block is smaller than the size (zero counts as one)
  function automatic logic [3:0] bin_count(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] s;
    logic [3:0]       cnt;
    s   = (size == '0) ? SizeW'(1) : size;
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      if ((SizeW'(MinBlock) << k) < s) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

endpackage

[rtl/scba_req_if.sv]
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] request_size;
  logic [7:0]  alignment;
  logic [17:0] block_address;
  logic        address_is_null;

  modport source (output valid, action, request_size, alignment, block_address,
                  address_is_null, input ready);
  modport sink (input valid, action, request_size, alignment, block_address,
                address_is_null, output ready);
endinterface

[rtl/scba_rsp_if.sv]
interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [17:0] granted_address;
  logic [2:0]  bin_used;

  modport source (output valid, status, granted_address, bin_used, input ready);
  modport sink (input valid, status, granted_address, bin_used, output ready);
endinterface

[rtl/size_class_block_allocator.sv]
// Size-class block allocator: each request beat allocates or frees at most one
// block from power-of-two bins of 16 bytes and up, each bin a LIFO free list
// kept in a single-port link memory. An alloc pops with one link memory read,
// a free pushes with one link memory write. An alloc that finds its bin empty
// carves a fresh page, one link write per block (PAGE_BYTES / block size writes,
// 256 for 16-byte blocks in 4 KiB pages), in place of the pop. A free whose
// address lies past the pool first wraps its index, one subtraction of the link
// count per cycle. A two-entry queue between the classifier and the list engine
// lets requests be accepted while a result waits; pages_allowed is written
// through cfg_we_i; the user must write it only while idle, as the block itself
// does not enforce it.
module size_class_block_allocator #(
  parameter int unsigned NUM_BINS   = 8,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned POOL_PAGES = 64,
  parameter int unsigned MAX_BLOCK  = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [scba_pkg::CfgW-1:0] cfg_wdata_i,
  scba_req_if.sink                  req,
  scba_rsp_if.source                rsp
);
  import scba_pkg::*;

  localparam int unsigned LinkCount = (PAGE_BYTES / MinBlock) * POOL_PAGES;

  logic push, full, pop, cmd_valid;
  cmd_t push_data, pop_data;

  scba_front #(
    .NUM_BINS  (NUM_BINS),
    .MAX_BLOCK (MAX_BLOCK),
    .LINK_COUNT(LinkCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  scba_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .pop_data_o (pop_data)
  );

  scba_back #(
    .NUM_BINS  (NUM_BINS),
    .PAGE_BYTES(PAGE_BYTES),
    .POOL_PAGES(POOL_PAGES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (pop_data),
    .cmd_pop_o  (pop),
    .rsp        (rsp)
  );
endmodule

[rtl/scba_fifo.sv]
module scba_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scba_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output scba_pkg::cmd_t pop_data_o
);
  import scba_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule

[rtl/scba_front.sv]
module scba_front #(
  parameter int unsigned NUM_BINS   = 8,
  parameter int unsigned MAX_BLOCK  = 2048,
  parameter int unsigned LINK_COUNT = 16384
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  scba_req_if.sink        req,
  output logic            push_o,
  output scba_pkg::cmd_t  push_data_o,
  input  logic            full_i
);
  import scba_pkg::*;

  localparam logic [31:0] LinkCount = 32'(LINK_COUNT);

  front_state_e    state_q, state_d;
  logic [31:0]     v_q, v_d;
  logic [BinW-1:0] bin_q, bin_d;

  logic [3:0]        cnt;
  logic              too_big;
  logic [BinW-1:0]   bin;
  logic [AlignW-1:0] align_eff;
  logic [11:0]       blk_bytes;
  logic [31:0]       v_in;
  logic              accept;

  // Classify the incoming beat
  always_comb begin
    cnt       = bin_count(req.request_size);
    too_big   = (req.request_size > SizeW'(MAX_BLOCK)) || (cnt >= 4'(NUM_BINS));
    bin       = cnt[BinW-1:0];
    align_eff = ((req.alignment & (req.alignment - 8'd1)) == 8'd0) ? req.alignment : 8'd0;
    blk_bytes = 12'(MinBlock) << bin;
    v_in      = 32'(req.block_address[AddrW-1:MinShift]);
  end

  assign req.ready = (state_q == F_IDLE) && !full_i;
  assign accept    = req.valid && req.ready;

  // Next state and queue push
  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    bin_d       = bin_q;
    push_o      = 1'b0;
    push_data_o = '{kind: CMD_NULL, bin: '0, idx: '0};
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          push_o = 1'b1;
          if (req.action) begin
            if (req.address_is_null) begin
              push_data_o.kind = CMD_NULL;
            end else if (too_big) begin
              push_data_o.kind = CMD_GENERAL;
            end else if (v_in >= LinkCount) begin
              // wrap the link index before pushing
              push_o  = 1'b0;
              v_d     = v_in;
              bin_d   = bin;
              state_d = F_REDUCE;
            end else begin
              push_data_o.kind = CMD_FREE;
              push_data_o.bin  = bin;
              push_data_o.idx  = v_in[IdxWMax-1:0];
            end
          end else if (too_big) begin
            push_data_o.kind = CMD_GENERAL;
          end else if ({4'd0, align_eff} > blk_bytes) begin
            push_data_o.kind = CMD_ALIGNED;
            push_data_o.bin  = bin;
          end else begin
            push_data_o.kind = CMD_ALLOC;
            push_data_o.bin  = bin;
          end
        end
      end
      F_REDUCE: begin
        if (v_q >= LinkCount) begin
          v_d = v_q - LinkCount;
        end else if (!full_i) begin
          push_o           = 1'b1;
          push_data_o.kind = CMD_FREE;
          push_data_o.bin  = bin_q;
          push_data_o.idx  = v_q[IdxWMax-1:0];
          state_d          = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    bin_q <= bin_d;
  end
endmodule

[rtl/scba_back.sv]
module scba_back #(
  parameter int unsigned NUM_BINS   = 8,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scba_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       cmd_valid_i,
  input  scba_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  scba_rsp_if.source                 rsp
);
  import scba_pkg::*;

  localparam int unsigned PageUnits = PAGE_BYTES / MinBlock;
  localparam int unsigned LinkCount = PageUnits * POOL_PAGES;
  localparam int unsigned LW  = (LinkCount > 1) ? $clog2(LinkCount) : 1;
  localparam int unsigned BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned PTW = $clog2(POOL_PAGES + 1);
  localparam int unsigned CW  = (PTW > CfgW) ? PTW : CfgW;
  localparam int unsigned CPW = $clog2(PageUnits + 1);

  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [LW:0]     heads_q [2**BW];
  logic [LW:0]     heads_d [2**BW];
  logic [PTW-1:0]  taken_q, taken_d;
  logic [CfgW-1:0] allowed_q;
  logic [LW-1:0]   idx_q, idx_d;
  logic [LW:0]     prev_q, prev_d;
  logic [CPW-1:0]  cnt_q, cnt_d;
  status_e         status_q, status_d;

  logic [LW:0]   link_mem [LinkCount];
  logic [LW:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [LW-1:0] mem_waddr, mem_raddr;
  logic [LW:0]   mem_wdata;

  logic             res_valid_q;
  status_e          res_status_q;
  logic [AddrW-1:0] res_addr_q;
  logic [BinW-1:0]  res_bin_q;
  logic             res_load;

  logic [BW-1:0]  b;
  logic [LW:0]    head;
  logic [LW-1:0]  units;
  logic [CPW-1:0] cap;
  logic [CW-1:0]  allowed_ext, limit;
  logic [LW-1:0]  base;

  always_comb begin
    b           = cmd_q.bin[BW-1:0];
    head        = heads_q[b];
    units       = LW'(1) << cmd_q.bin;
    cap         = CPW'(PageUnits) >> cmd_q.bin;
    allowed_ext = CW'(allowed_q);
    limit       = (allowed_ext < CW'(POOL_PAGES)) ? allowed_ext : CW'(POOL_PAGES);
    base        = LW'(taken_q) * LW'(PageUnits);
  end

  // Sequence one command: pop, push, carve a page, or report a fallback status
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    heads_d   = heads_q;
    taken_d   = taken_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    res_load  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = B_DECODE;
        end
      end
      B_DECODE: begin
        state_d = B_DONE;
        case (cmd_q.kind)
          CMD_NULL:    status_d = ST_NULL;
          CMD_GENERAL: status_d = ST_GENERAL;
          CMD_ALIGNED: status_d = ST_ALIGNED;
          CMD_FREE: begin
            mem_we     = 1'b1;
            mem_waddr  = cmd_q.idx[LW-1:0];
            mem_wdata  = head;
            heads_d[b] = {1'b0, cmd_q.idx[LW-1:0]};
            status_d   = ST_FREED;
          end
          CMD_ALLOC: begin
            if (!head[LW]) begin
              mem_re    = 1'b1;
              mem_raddr = head[LW-1:0];
              idx_d     = head[LW-1:0];
              state_d   = B_POP;
            end else if (CW'(taken_q) >= limit) begin
              status_d = ST_NOPAGE;
            end else begin
              taken_d = taken_q + PTW'(1);
              if (cap == '0) begin
                status_d = ST_NOPAGE;
              end else begin
                idx_d   = base;
                prev_d  = {1'b1, LW'(0)};
                cnt_d   = '0;
                state_d = B_CARVE;
              end
            end
          end
          default: status_d = ST_GENERAL;
        endcase
      end
      B_POP: begin
        heads_d[b] = rdata_q;
        status_d   = ST_ALLOC;
        state_d    = B_DONE;
      end
      B_CARVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = prev_q;
        if (cnt_q == cap - CPW'(1)) begin
          // last block is granted; the list resumes at its link
          heads_d[b] = prev_q;
          status_d   = ST_ALLOC;
          state_d    = B_DONE;
        end else begin
          prev_d = {1'b0, idx_q};
          idx_d  = idx_q + units;
          cnt_d  = cnt_q + CPW'(1);
        end
      end
      B_DONE: begin
        if (!res_valid_q || rsp.ready) begin
          res_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Link store
  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= link_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      taken_q     <= '0;
      allowed_q   <= CfgReset;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 2**BW; i++) heads_q[i] <= {1'b1, LW'(0)};
    end else begin
      state_q <= state_d;
      taken_q <= taken_d;
      heads_q <= heads_d;
      if (cfg_we_i) allowed_q <= cfg_wdata_i;
      if (res_load) res_valid_q <= 1'b1;
      else if (rsp.ready) res_valid_q <= 1'b0;
    end
  end

  // Hold command context and result beat
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    prev_q   <= prev_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    if (res_load) begin
      res_status_q <= status_q;
      res_addr_q   <= (status_q == ST_ALLOC) ? AddrW'(32'(idx_q) << MinShift) : '0;
      res_bin_q    <= cmd_q.bin;
    end
  end

  assign rsp.valid           = res_valid_q;
  assign rsp.status          = res_status_q;
  assign rsp.granted_address = res_addr_q;
  assign rsp.bin_used        = res_bin_q;
endmodule

[rtl/scba_checker.sv]
module scba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [17:0] out_addr,
  input logic [2:0]  out_bin
);
  import scba_pkg::*;

  // Status codes stay in the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status <= ST_NULL))
    else $error("status code out of range");

  // Only a grant carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status != ST_ALLOC) |-> (out_addr == '0))
    else $error("address on non-grant result");

  // Fallbacks without a bin report bin zero
  a_bin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_status == ST_GENERAL || out_status == ST_NULL)) |-> (out_bin == '0))
    else $error("bin reported on general or null result");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_addr)))
    else $error("result beat dropped or changed while stalled");
endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_status(rsp.status),
  .out_addr  (rsp.granted_address),
  .out_bin   (rsp.bin_used)
);

[sim/tb_size_class_block_allocator.sv]
`timescale 1ns / 1ps

module tb_size_class_block_allocator;
  import scba_pkg::*;

  localparam int unsigned LinkDepth   = 16384;
  localparam int unsigned PagesInPool = 64;
  localparam int unsigned PageUnits   = 256;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    status_e     st;
    logic [17:0] addr;
    logic [2:0]  bin;
  } alloc_result_t;

  typedef struct packed {
    logic        action;
    logic [31:0] size;
    logic [7:0]  align;
    logic [17:0] addr;
    logic        is_null;
    logic        typed;
    status_e     st;
    logic [17:0] exp_addr;
    logic [2:0]  exp_bin;
  } stim_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  scba_req_if req ();
  scba_rsp_if rsp ();

  size_class_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req),
    .rsp        (rsp)
  );

  // Shadow allocator state: bit 14 of a head or link marks null
  logic [14:0] heads [8];
  logic [14:0] links [LinkDepth];
  int unsigned taken_pages;
  int unsigned allowed_pages;

  alloc_result_t pending_results[$];
  logic [17:0]   live_blocks[8][$];
  stim_row_t     directed_rows[$];

  int unsigned errors;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned stall_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  int unsigned status_seen [6];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bin for a size, -1 when it fits no bin
  function automatic int size_to_bin(input logic [31:0] size);
    logic [31:0] s;
    int          b;
    s = (size == 0) ? 32'd1 : size;
    if (s > 32'd2048) return -1;
    b = 0;
    while ((32'd16 << b) < s) b++;
    return b;
  endfunction

  // Advance the shadow allocator by one request and return its result
  function automatic alloc_result_t allocator_step(input logic action,
                                                   input logic [31:0] size,
                                                   input logic [7:0] align,
                                                   input logic [17:0] addr,
                                                   input logic is_null);
    alloc_result_t r;
    int          b;
    int unsigned units, cap, base, lim, idx;
    logic [14:0] prev;
    logic [8:0]  al;
    r = '{st: ST_ALLOC, addr: '0, bin: '0};
    if (action) begin
      if (is_null) begin
        r.st = ST_NULL;
        return r;
      end
      b = size_to_bin(size);
      if (b < 0) begin
        r.st = ST_GENERAL;
        return r;
      end
      idx = addr >> 4;
      links[idx] = heads[b];
      heads[b] = 15'(idx);
      r.st = ST_FREED;
      r.bin = 3'(b);
      return r;
    end
    al = {1'b0, align};
    if (al != 0 && (al & (al - 9'd1)) != 0) al = '0;
    b = size_to_bin(size);
    if (b < 0) begin
      r.st = ST_GENERAL;
      return r;
    end
    r.bin = 3'(b);
    units = 1 << b;
    if (al > 16 * units) begin
      r.st = ST_ALIGNED;
      return r;
    end
    if (!heads[b][14]) begin
      idx = heads[b][13:0];
      heads[b] = links[idx];
      r.addr = 18'(idx * 16);
      return r;
    end
    lim = (allowed_pages < PagesInPool) ? allowed_pages : PagesInPool;
    if (taken_pages >= lim) begin
      r.st = ST_NOPAGE;
      return r;
    end
    cap = 4096 / (16 * units);
    base = taken_pages * PageUnits;
    taken_pages++;
    prev = 15'h4000;
    for (int i = 0; i < cap; i++) begin
      idx = (base + i * units) % LinkDepth;
      links[idx] = prev;
      prev = 15'(idx);
    end
    heads[b] = links[prev[13:0]];
    r.addr = 18'(prev[13:0] * 16);
    return r;
  endfunction

  // Predict on every accepted request beat
  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready) begin
      pending_results.push_back(allocator_step(req.action, req.request_size,
                                               req.alignment, req.block_address,
                                               req.address_is_null));
      beats_in++;
    end
  end

  // Check every accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h bin=%0d", $realtime,
                 rsp.status, rsp.granted_address, rsp.bin_used);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp.status !== e.st || rsp.granted_address !== e.addr ||
            rsp.bin_used !== e.bin) begin
          $display("%0t: mismatch expected status=%0d addr=%h bin=%0d, actual status=%0d addr=%h bin=%0d",
                   $realtime, e.st, e.addr, e.bin, rsp.status, rsp.granted_address,
                   rsp.bin_used);
          errors++;
        end
        if (rsp.status < 6) status_seen[rsp.status]++;
        if (rsp.status == ST_ALLOC) live_blocks[rsp.bin_used].push_back(rsp.granted_address);
      end
    end
  end

  // Watchdog: count cycles with work pending but no beat moving
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (pending_results.size() == 0 && !req.valid)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $realtime, StallLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready = 1'b0;
      end else begin
        rsp.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request beat and hold it until accepted
  task automatic send_request(input logic action, input logic [31:0] size,
                              input logic [7:0] align, input logic [17:0] addr,
                              input logic is_null);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.action = action;
    req.request_size = size;
    req.alignment = align;
    req.block_address = addr;
    req.address_is_null = is_null;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  // Wait until every result is back, then let the block settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_pages_allowed(input logic [CfgW-1:0] value);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    allowed_pages = value;
  endtask

  // Size drawn from the range that maps to one bin
  function automatic logic [31:0] size_in_bin(input int b);
    if (b == 0) return $urandom_range(16, 0);
    return $urandom_range(16 << b, (8 << b) + 1);
  endfunction

  // Random traffic: mostly allocs and frees of live blocks, some noise
  task automatic random_traffic(input int unsigned count);
    int unsigned pick, roll;
    int          b;
    logic [17:0] a;
    logic [7:0]  al;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      b = $urandom_range(7);
      al = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(7));
      if ($urandom_range(4) == 0) al = '0;
      if (roll < 50) begin
        send_request(1'b0, size_in_bin(b), al, 18'($urandom), 1'b0);
      end else if (roll < 85) begin
        b = -1;
        for (int k = 0; k < 8; k++) begin
          pick = (k + $urandom_range(7)) % 8;
          if (b < 0 && live_blocks[pick].size() != 0) b = pick;
        end
        if (b < 0) begin
          send_request(1'b0, size_in_bin($urandom_range(7)), 8'd0, '0, 1'b0);
        end else begin
          pick = $urandom_range(live_blocks[b].size() - 1);
          a = live_blocks[b][pick];
          live_blocks[b].delete(pick);
          send_request(1'b1, size_in_bin(b), 8'($urandom), a | 18'($urandom_range(15)),
                       1'b0);
        end
      end else begin
        send_request(1'($urandom), $urandom, 8'($urandom), 18'($urandom),
                     1'($urandom_range(2) == 0));
      end
    end
  endtask

  task automatic add_row(input logic action, input logic [31:0] size,
                         input logic [7:0] align, input logic [17:0] addr,
                         input logic is_null, input logic typed, input status_e st,
                         input logic [17:0] exp_addr, input logic [2:0] exp_bin);
    directed_rows.push_back('{action, size, align, addr, is_null, typed, st, exp_addr,
                              exp_bin});
  endtask

  initial begin
    stim_row_t     row;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    stall_count = 0;
    hold_request = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 51;
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    for (int i = 0; i < 8; i++) heads[i] = 15'h4000;
    for (int i = 0; i < LinkDepth; i++) links[i] = '0;
    taken_pages = 0;
    allowed_pages = CfgReset;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.action = 1'b0;
    req.request_size = '0;
    req.alignment = '0;
    req.block_address = '0;
    req.address_is_null = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: extremes, every status but out of pages, special cases
    add_row(0, 32'd0, 8'd0, '0, 0, 1, ST_ALLOC, 18'd4080, 3'd0);
    add_row(0, 32'd16, 8'd0, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd2048, 8'd3, '0, 0, 1, ST_ALLOC, 18'd6144, 3'd7);
    add_row(0, 32'd2049, 8'd0, '0, 0, 1, ST_GENERAL, '0, '0);
    add_row(0, 32'hFFFF_FFFF, 8'hFF, 18'h3FFFF, 0, 1, ST_GENERAL, '0, '0);
    add_row(1, 32'hFFFF_FFFF, 8'hFF, 18'h3FFFF, 1, 1, ST_NULL, '0, '0);
    add_row(1, 32'd4096, 8'd0, 18'd64, 0, 1, ST_GENERAL, '0, '0);
    add_row(0, 32'd16, 8'd32, '0, 0, 1, ST_ALIGNED, '0, 3'd0);
    add_row(0, 32'd64, 8'd128, '0, 0, 1, ST_ALIGNED, '0, 3'd2);
    add_row(0, 32'd128, 8'd128, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd2048, 8'd0, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd2048, 8'd0, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(1, 32'd2048, 8'd0, 18'd4096, 0, 1, ST_FREED, '0, 3'd7);
    add_row(0, 32'd2000, 8'd0, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(1, 32'd0, 8'd0, 18'd4080, 0, 1, ST_FREED, '0, 3'd0);
    add_row(1, 32'd17, 8'd0, 18'h3FFFF, 0, 1, ST_FREED, '0, 3'd1);
    add_row(0, 32'd32, 8'd0, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd1, 8'd1, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd1024, 8'd64, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(0, 32'd256, 8'd255, '0, 0, 0, ST_ALLOC, '0, '0);
    add_row(1, 32'd1, 8'd0, 18'd0, 1, 1, ST_NULL, '0, '0);

    // Walk the table; typed rows replace the prediction once it is queued
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.action, row.size, row.align, row.addr, row.is_null);
      if (row.typed) begin
        pending_results[pending_results.size() - 1] =
          '{st: row.st, addr: row.exp_addr, bin: row.exp_bin};
      end
    end
    drain();

    // Tight page limit: only lists already filled can serve
    write_pages_allowed(7'd1);
    random_traffic(430);
    drain();

    // Limit above the pool size, idling swapped
    send_idle_pct = 51;
    recv_idle_pct = 36;
    write_pages_allowed(7'd127);
    random_traffic(500);
    drain();

    // Mid limit, no idling, one long result hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_pages_allowed(7'd20);
    hold_request = 1'b1;
    random_traffic(500);
    drain();
    repeat (50) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results: alloc %0d, freed %0d, general %0d,",
             beats_in, beats_out, status_seen[0], status_seen[1], status_seen[2]);
    $display("  aligned %0d, out of pages %0d, null %0d; page limits 64, 1, 127, 20.",
             status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
